// File: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, command types and helpers for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int CX_W   = COL_W + 1;
    localparam int RX_W   = ROW_W + 1;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);
    localparam int FLAT_W = $clog2((ROWS + 1) * COLUMNS + 1);
    localparam int WIDE_W = (FLAT_W > 12) ? FLAT_W : 12;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    localparam int TAB_STOP = 8;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_MOVE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] PRINT_FIRST = 8'h20;
    localparam logic [7:0] PRINT_LAST  = 8'h7F;
    localparam logic [7:0] BLANK_CHAR  = 8'h20;

    localparam logic [15:0] ATTR_MASK = 16'hFF00;

    localparam logic REG_BACKGROUND = 1'b0;
    localparam logic REG_FOREGROUND = 1'b1;

    typedef enum logic [3:0] {
        CMD_PRINT,
        CMD_BS,
        CMD_TAB,
        CMD_CR,
        CMD_LF,
        CMD_IGNORE,
        CMD_MOVE,
        CMD_CLEAR,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [10:0]       cell_index;
    } cmd_t;

    function automatic logic [WIDE_W-1:0] flat_of(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
        return WIDE_W'(row) * WIDE_W'(COLUMNS) + WIDE_W'(col);
    endfunction

endpackage

// File: rtl/core/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Decodes incoming items into commands and clamps cursor moves.
// ----------------------------------------------------------------------------
module tcw_front (
    input  logic                      push,
    input  logic [1:0]                operation,
    input  logic [7:0]                char_code,
    input  logic [7:0]                cursor_col,
    input  logic [7:0]                cursor_row,
    input  logic [10:0]               cell_index,
    input  logic                      queue_full,
    output logic                      full,
    output logic                      cmd_push,
    output tcw_pkg::cmd_t             cmd
);

    tcw_pkg::cmd_kind_t char_kind;

    always_comb
    begin
        unique case (char_code) inside
            tcw_pkg::CH_BS:                               char_kind = tcw_pkg::CMD_BS;
            tcw_pkg::CH_TAB:                              char_kind = tcw_pkg::CMD_TAB;
            tcw_pkg::CH_CR:                               char_kind = tcw_pkg::CMD_CR;
            tcw_pkg::CH_LF:                               char_kind = tcw_pkg::CMD_LF;
            [tcw_pkg::PRINT_FIRST:tcw_pkg::PRINT_LAST]:  char_kind = tcw_pkg::CMD_PRINT;
            default:                                      char_kind = tcw_pkg::CMD_IGNORE;
        endcase
    end

    always_comb
    begin
        cmd.code       = char_code;
        cmd.cell_index = cell_index;
        cmd.col        = ({1'b0, cursor_col} < 9'(tcw_pkg::COLUMNS))
                         ? tcw_pkg::COL_W'(cursor_col) : tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
        cmd.row        = ({1'b0, cursor_row} < 9'(tcw_pkg::ROWS))
                         ? tcw_pkg::ROW_W'(cursor_row) : tcw_pkg::ROW_W'(tcw_pkg::ROWS);
        unique case (operation)
            tcw_pkg::OP_PUT:   cmd.kind = char_kind;
            tcw_pkg::OP_MOVE:  cmd.kind = tcw_pkg::CMD_MOVE;
            tcw_pkg::OP_CLEAR: cmd.kind = tcw_pkg::CMD_CLEAR;
            tcw_pkg::OP_READ:  cmd.kind = tcw_pkg::CMD_READ;
            default:           cmd.kind = tcw_pkg::CMD_IGNORE;
        endcase
    end

    assign full     = queue_full;
    assign cmd_push = push && !queue_full;

endmodule

// File: rtl/core/tcw_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tcw_cmd_fifo
// Short command queue between the decoder and the screen engine.
// ----------------------------------------------------------------------------
module tcw_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  tcw_pkg::cmd_t  wr_data,
    output logic           full,
    input  logic           rd_en,
    output tcw_pkg::cmd_t  rd_data,
    output logic           empty
);

    tcw_pkg::cmd_t                    slots_reg [tcw_pkg::CMD_DEPTH];
    logic [tcw_pkg::CMD_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tcw_pkg::CMD_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tcw_pkg::CMD_PTR_W:0]      count_reg, count_next;
    logic                             do_wr, do_rd;

    assign full    = (count_reg == (tcw_pkg::CMD_PTR_W+1)'(tcw_pkg::CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == tcw_pkg::CMD_PTR_W'(tcw_pkg::CMD_DEPTH - 1))
                          ? '0 : wr_ptr_reg + tcw_pkg::CMD_PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == tcw_pkg::CMD_PTR_W'(tcw_pkg::CMD_DEPTH - 1))
                          ? '0 : rd_ptr_reg + tcw_pkg::CMD_PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (tcw_pkg::CMD_PTR_W+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (tcw_pkg::CMD_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/core/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Screen engine: cursor, colour registers, screen memory, scroll and clear
// sweeps, and the result register.
// ----------------------------------------------------------------------------
module tcw_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  tcw_pkg::cmd_t  cmd,
    output logic           cmd_take,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [3:0]     cfg_data,
    input  logic           pop,
    output logic           empty,
    output logic [11:0]    cursor_index,
    output logic [15:0]    read_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BS,
        ST_READ,
        ST_SCROLL,
        ST_CLEAR
    } state_t;

    state_t                          state_reg, state_next;
    logic [tcw_pkg::COL_W-1:0]       col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]       row_reg, row_next;
    logic [3:0]                      bg_reg, fg_reg;
    logic                            res_valid_reg, res_valid_next;
    logic [11:0]                     res_cursor_reg, res_cursor_next;
    logic [15:0]                     res_data_reg, res_data_next;
    logic [tcw_pkg::CNT_W-1:0]       k_reg, k_next;
    logic                            pend_reg, pend_next;
    logic [tcw_pkg::ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    logic [tcw_pkg::ADDR_W-1:0]      bs_addr_reg, bs_addr_next;

    logic [15:0]                     screen_mem [tcw_pkg::CELL_COUNT];
    logic [15:0]                     rd_data_reg;
    logic                            mem_we, mem_re;
    logic [tcw_pkg::ADDR_W-1:0]      mem_waddr, mem_raddr;
    logic [15:0]                     mem_wdata;

    logic [tcw_pkg::CX_W-1:0]        pc_col;
    logic [tcw_pkg::RX_W-1:0]        pc_row;
    logic                            pc_scroll;
    logic [tcw_pkg::WIDE_W-1:0]      flat, bs_flat, res_flat;
    logic                            print_wr, bs_wr, read_ok;
    logic                            slot_free, load_res;
    logic [15:0]                     res_data_val;
    logic [7:0]                      attr;

    assign attr      = {bg_reg, fg_reg};
    assign flat      = tcw_pkg::flat_of(row_reg, col_reg);
    assign bs_flat   = flat - tcw_pkg::WIDE_W'(1);
    assign print_wr  = (cmd.kind == tcw_pkg::CMD_PRINT)
                       && (flat < tcw_pkg::WIDE_W'(tcw_pkg::CELL_COUNT));
    assign bs_wr     = (cmd.kind == tcw_pkg::CMD_BS) && (col_reg != '0)
                       && (bs_flat < tcw_pkg::WIDE_W'(tcw_pkg::CELL_COUNT));
    assign read_ok   = tcw_pkg::WIDE_W'(cmd.cell_index) < tcw_pkg::WIDE_W'(tcw_pkg::CELL_COUNT);
    assign slot_free = !res_valid_reg || pop;
    assign res_flat  = tcw_pkg::flat_of(row_next, col_next);

    // cursor update for put-character commands
    always_comb
    begin
        pc_col = tcw_pkg::CX_W'(col_reg);
        pc_row = tcw_pkg::RX_W'(row_reg);
        unique case (cmd.kind)
            tcw_pkg::CMD_PRINT:
                pc_col = pc_col + tcw_pkg::CX_W'(1);
            tcw_pkg::CMD_BS:
                if (col_reg != '0)
                begin
                    pc_col = pc_col - tcw_pkg::CX_W'(1);
                end
            tcw_pkg::CMD_TAB:
                pc_col = (pc_col + tcw_pkg::CX_W'(tcw_pkg::TAB_STOP))
                         & ~tcw_pkg::CX_W'(tcw_pkg::TAB_STOP - 1);
            tcw_pkg::CMD_CR:
                pc_col = '0;
            tcw_pkg::CMD_LF:
            begin
                pc_col = '0;
                pc_row = pc_row + tcw_pkg::RX_W'(1);
            end
            default: ;
        endcase
        if (pc_col >= tcw_pkg::CX_W'(tcw_pkg::COLUMNS))
        begin
            pc_col = '0;
            pc_row = pc_row + tcw_pkg::RX_W'(1);
        end
        pc_scroll = (pc_row >= tcw_pkg::RX_W'(tcw_pkg::ROWS));
        if (pc_scroll)
        begin
            pc_row = pc_row - tcw_pkg::RX_W'(1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        bs_addr_next   = bs_addr_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        cmd_take       = 1'b0;
        load_res       = 1'b0;
        res_data_val   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_take = 1'b1;
                    unique case (cmd.kind)
                        tcw_pkg::CMD_MOVE:
                        begin
                            col_next = cmd.col;
                            row_next = cmd.row;
                            load_res = 1'b1;
                        end
                        tcw_pkg::CMD_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            k_next     = '0;
                            state_next = ST_CLEAR;
                        end
                        tcw_pkg::CMD_READ:
                        begin
                            if (read_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = tcw_pkg::ADDR_W'(cmd.cell_index);
                                state_next = ST_READ;
                            end
                            else
                            begin
                                load_res = 1'b1;
                            end
                        end
                        default:
                        begin
                            col_next = tcw_pkg::COL_W'(pc_col);
                            row_next = tcw_pkg::ROW_W'(pc_row);
                            if (bs_wr)
                            begin
                                mem_re       = 1'b1;
                                mem_raddr    = tcw_pkg::ADDR_W'(bs_flat);
                                bs_addr_next = tcw_pkg::ADDR_W'(bs_flat);
                                state_next   = ST_BS;
                            end
                            else
                            begin
                                if (print_wr)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = tcw_pkg::ADDR_W'(flat);
                                    mem_wdata = {attr, cmd.code};
                                end
                                if (pc_scroll)
                                begin
                                    k_next     = '0;
                                    pend_next  = 1'b0;
                                    state_next = ST_SCROLL;
                                end
                                else
                                begin
                                    load_res = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_BS:
            begin
                mem_we     = 1'b1;
                mem_waddr  = bs_addr_reg;
                mem_wdata  = rd_data_reg & tcw_pkg::ATTR_MASK;
                load_res   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                res_data_val = rd_data_reg;
                load_res     = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_SCROLL:
            begin
                // read k (one row down, or in place on the last row), write k-1
                if (k_reg != tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT))
                begin
                    mem_re = 1'b1;
                    if (k_reg < tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS))
                    begin
                        mem_raddr = tcw_pkg::ADDR_W'(k_reg + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS));
                    end
                    else
                    begin
                        mem_raddr = tcw_pkg::ADDR_W'(k_reg);
                    end
                    k_next         = k_reg + tcw_pkg::CNT_W'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = tcw_pkg::ADDR_W'(k_reg);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    if (pend_addr_reg >= tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS))
                    begin
                        mem_wdata = rd_data_reg & tcw_pkg::ATTR_MASK;
                    end
                    else
                    begin
                        mem_wdata = rd_data_reg;
                    end
                end
                if (pend_reg && (k_reg == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT)))
                begin
                    load_res   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = tcw_pkg::ADDR_W'(k_reg);
                mem_wdata = {attr, tcw_pkg::BLANK_CHAR};
                k_next    = k_reg + tcw_pkg::CNT_W'(1);
                if (k_reg == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1))
                begin
                    load_res   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (load_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
        res_cursor_next = load_res ? res_flat[11:0] : res_cursor_reg;
        res_data_next   = load_res ? res_data_val : res_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            bg_reg         <= 4'd0;
            fg_reg         <= 4'd15;
            res_valid_reg  <= 1'b0;
            res_cursor_reg <= '0;
            res_data_reg   <= '0;
            k_reg          <= '0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            bs_addr_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            res_valid_reg  <= res_valid_next;
            res_cursor_reg <= res_cursor_next;
            res_data_reg   <= res_data_next;
            k_reg          <= k_next;
            pend_reg       <= pend_next;
            pend_addr_reg  <= pend_addr_next;
            bs_addr_reg    <= bs_addr_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tcw_pkg::REG_BACKGROUND: bg_reg <= cfg_data;
                    tcw_pkg::REG_FOREGROUND: fg_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= screen_mem[mem_raddr];
        end
    end

    assign empty        = !res_valid_reg;
    assign cursor_index = res_cursor_reg;
    assign read_data    = res_data_reg;

endmodule

// File: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text screen with cursor: decoder, command queue and screen engine.
// ----------------------------------------------------------------------------
// Path: an input transfer is written into the command queue; the screen engine then takes
//   it and registers the result. A backspace that clears a cell and an in-range read cell
//   do one memory read then write/return. Clear and a put that scrolls sweep one cell per
//   cycle; no new command is taken while busy or while an unpopped result is held.
// Reset: cursor at 0,0, colours background 0 / foreground 15, queues empty; screen
//   contents are undefined until written, no clearing pass.
module text_console_writer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [1:0]   operation,
    input  logic [7:0]   char_code,
    input  logic [7:0]   cursor_col,
    input  logic [7:0]   cursor_row,
    input  logic [10:0]  cell_index,
    output logic         empty,
    input  logic         pop,
    output logic [11:0]  cursor_index,
    output logic [15:0]  read_data,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [3:0]   cfg_data
);

    tcw_pkg::cmd_t  dec_cmd;
    tcw_pkg::cmd_t  q_cmd;
    logic           dec_push;
    logic           q_full;
    logic           q_empty;
    logic           q_take;

    assign cfg_ready = 1'b1;

    tcw_front u_front (
        .push       (push),
        .operation  (operation),
        .char_code  (char_code),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cell_index (cell_index),
        .queue_full (q_full),
        .full       (full),
        .cmd_push   (dec_push),
        .cmd        (dec_cmd)
    );

    tcw_cmd_fifo u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (dec_push),
        .wr_data (dec_cmd),
        .full    (q_full),
        .rd_en   (q_take),
        .rd_data (q_cmd),
        .empty   (q_empty)
    );

    tcw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (!q_empty),
        .cmd          (q_cmd),
        .cmd_take     (q_take),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pop          (pop),
        .empty        (empty),
        .cursor_index (cursor_index),
        .read_data    (read_data)
    );

endmodule

// File: bench/tb_text_console_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer. A shadow copy of the screen,
// cursor and colours predicts the cursor index and read data of every command.
// Commands are pushed in random bursts and results are popped against a varying
// stall pattern. Colours change only between phases, once the block is quiet.
// ----------------------------------------------------------------------------
module tb_text_console_writer;

    import tcw_pkg::*;

    localparam int SETTLE_CYCLES  = 2200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 175;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  code;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [10:0] idx;
    } console_cmd_t;

    typedef struct {
        logic [11:0] cursor;
        logic [15:0] data;
    } console_result_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic        full;
    logic [1:0]  operation  = '0;
    logic [7:0]  char_code  = '0;
    logic [7:0]  cursor_col = '0;
    logic [7:0]  cursor_row = '0;
    logic [10:0] cell_index = '0;
    logic        empty;
    logic        pop        = 1'b0;
    logic [11:0] cursor_index;
    logic [15:0] read_data;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic        cfg_index  = REG_BACKGROUND;
    logic [3:0]  cfg_data   = '0;

    console_cmd_t    command_queue[$];
    console_result_t cursor_reports[$];
    console_cmd_t    held_cmd;

    logic [15:0] shadow_screen [CELL_COUNT];
    int          shadow_col = 0;
    int          shadow_row = 0;
    logic [3:0]  shadow_bg  = 4'd0;
    logic [3:0]  shadow_fg  = 4'd15;

    int err_count    = 0;
    int burst_left   = 1;
    int gap_left     = 0;
    int pop_pct      = 100;
    int pattern_left = 0;
    int stall_cycles = 0;

    text_console_writer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .char_code    (char_code),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row),
        .cell_index   (cell_index),
        .empty        (empty),
        .pop          (pop),
        .cursor_index (cursor_index),
        .read_data    (read_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    // Shadow of the screen engine; appends the result the command must produce.
    function automatic void advance_console(input console_cmd_t c);
        int          flat;
        int          k;
        logic [15:0] attr;
        logic [15:0] rd;
        attr = {shadow_bg, shadow_fg, 8'h00};
        rd   = '0;
        flat = shadow_row * COLUMNS + shadow_col;
        case (c.op)
            OP_PUT:
            begin
                if (c.code == CH_BS && shadow_col > 0)
                begin
                    if (flat - 1 < CELL_COUNT)
                        shadow_screen[flat - 1] = shadow_screen[flat - 1] & ATTR_MASK;
                    shadow_col--;
                end
                else if (c.code == CH_TAB)
                    shadow_col = (shadow_col + TAB_STOP) & ~(TAB_STOP - 1);
                else if (c.code == CH_CR)
                    shadow_col = 0;
                else if (c.code == CH_LF)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                else if (c.code >= PRINT_FIRST && c.code <= PRINT_LAST)
                begin
                    if (flat < CELL_COUNT)
                        shadow_screen[flat] = attr | {8'h00, c.code};
                    shadow_col++;
                end
                if (shadow_col >= COLUMNS)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                if (shadow_row >= ROWS)
                begin
                    for (k = 0; k + COLUMNS < CELL_COUNT; k++)
                        shadow_screen[k] = shadow_screen[k + COLUMNS];
                    for (k = CELL_COUNT - COLUMNS; k < CELL_COUNT; k++)
                        shadow_screen[k] = shadow_screen[k - COLUMNS] & ATTR_MASK;
                    if (shadow_row > 0)
                        shadow_row--;
                end
            end
            OP_MOVE:
            begin
                shadow_col = (int'(c.col) < COLUMNS) ? int'(c.col) : COLUMNS;
                shadow_row = (int'(c.row) < ROWS) ? int'(c.row) : ROWS;
            end
            OP_CLEAR:
            begin
                for (k = 0; k < CELL_COUNT; k++)
                    shadow_screen[k] = attr | {8'h00, BLANK_CHAR};
                shadow_col = 0;
                shadow_row = 0;
            end
            OP_READ:
            begin
                if (int'(c.idx) < CELL_COUNT)
                    rd = shadow_screen[c.idx];
            end
        endcase
        cursor_reports.push_back('{cursor: 12'(shadow_row * COLUMNS + shadow_col), data: rd});
    endfunction

    // Unused fields carry random bits so every input bit toggles.
    function automatic console_cmd_t noise_cmd(input logic [1:0] op);
        console_cmd_t c;
        c.op   = op;
        c.code = 8'($urandom);
        c.col  = 8'($urandom);
        c.row  = 8'($urandom);
        c.idx  = 11'($urandom);
        return c;
    endfunction

    function automatic void queue_put(input logic [7:0] code);
        console_cmd_t c;
        c = noise_cmd(OP_PUT);
        c.code = code;
        command_queue.push_back(c);
    endfunction

    function automatic void queue_move(input logic [7:0] col, input logic [7:0] row);
        console_cmd_t c;
        c = noise_cmd(OP_MOVE);
        c.col = col;
        c.row = row;
        command_queue.push_back(c);
    endfunction

    function automatic void queue_read(input logic [10:0] idx);
        console_cmd_t c;
        c = noise_cmd(OP_READ);
        c.idx = idx;
        command_queue.push_back(c);
    endfunction

    function automatic void queue_clear();
        command_queue.push_back(noise_cmd(OP_CLEAR));
    endfunction

    function automatic logic [7:0] any_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 8'($urandom_range(PRINT_FIRST, PRINT_LAST));
        else if (r < 60)
            return CH_LF;
        else if (r < 66)
            return CH_CR;
        else if (r < 75)
            return CH_TAB;
        else if (r < 88)
            return CH_BS;
        else if ($urandom_range(0, 1))
            return 8'($urandom_range(8'h80, 8'hFF));
        else
            return 8'($urandom_range(8'h00, 8'h1F));
    endfunction

    function automatic void queue_random(input int count);
        int n;
        int len;
        int i;
        int r;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 99) < 55)
            begin
                // line of text, sometimes long enough to wrap
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 60);
                for (i = 0; i < len; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 5)
                        queue_put(CH_BS);
                    else if (r < 8)
                        queue_put(CH_TAB);
                    else if (r < 20)
                        queue_read(11'($urandom_range(0, CELL_COUNT - 1)));
                    else if (r < 22)
                        queue_put(any_code());
                    else
                        queue_put(8'($urandom_range(PRINT_FIRST, PRINT_LAST)));
                end
                n += len;
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    queue_put(CH_CR);
                    queue_put(CH_LF);
                    n += 2;
                end
                else if (r < 85)
                begin
                    queue_put(CH_LF);
                    n++;
                end
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    queue_put(any_code());
                else if (r < 50)
                    queue_move(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, COLUMNS + 4)),
                               ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, ROWS + 3)));
                else if (r < 96)
                    queue_read(($urandom_range(0, 6) == 0) ? 11'($urandom)
                                                          : 11'($urandom_range(0, CELL_COUNT - 1)));
                else
                    queue_clear();
                n++;
            end
        end
    endfunction

    task automatic write_colour(input logic idx, input logic [3:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_BACKGROUND)
            shadow_bg = val;
        else
            shadow_fg = val;
    endtask

    task automatic wait_drained();
        while (command_queue.size() != 0 || push || cursor_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Command driver: bursts of transfers separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push       <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (push && !full)
            begin
                advance_console(held_cmd);
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
                end
            end
            if (!(push && full))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (command_queue.size() > 0)
                begin
                    held_cmd = command_queue.pop_front();
                    push       <= 1'b1;
                    operation  <= held_cmd.op;
                    char_code  <= held_cmd.code;
                    cursor_col <= held_cmd.col;
                    cursor_row <= held_cmd.row;
                    cell_index <= held_cmd.idx;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Result side stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop          <= 1'b0;
            pop_pct      = 100;
            pattern_left = 0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pop_pct = 100;
                    1: pop_pct = 75;
                    2: pop_pct = 40;
                    default: pop_pct = 10;
                endcase
                pattern_left = $urandom_range(20, 200);
            end
            else
                pattern_left--;
            pop <= ($urandom_range(1, 100) <= pop_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        console_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (cursor_reports.size() == 0)
                report_mismatch($sformatf("result with nothing pending, cursor %0d", cursor_index));
            else
            begin
                want = cursor_reports.pop_front();
                if (cursor_index !== want.cursor)
                    report_mismatch($sformatf("cursor_index %0d, want %0d",
                                              cursor_index, want.cursor));
                if (read_data !== want.data)
                    report_mismatch($sformatf("read_data %h, want %h", read_data, want.data));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", stall_cycles);
                $display("TB_ERROR");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int phase;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no screen reads until the first clear has written every cell
        queue_put(CH_CR);
        queue_put(CH_TAB);
        queue_put(8'h41);
        queue_put(CH_BS);
        queue_put(CH_LF);
        queue_put(8'h00);
        queue_put(8'hFF);
        queue_clear();
        queue_read(11'd0);
        queue_put(PRINT_FIRST);
        queue_put(PRINT_LAST);
        queue_put(8'h80);
        queue_put(CH_BS);
        queue_read(11'd1);
        queue_move(8'd0, 8'd0);
        queue_put(CH_BS);
        queue_move(8'(COLUMNS - 1), 8'd0);
        queue_put(CH_TAB);
        queue_move(8'hFF, 8'hFF);
        queue_put(8'h5A);
        queue_read(11'(CELL_COUNT - 1));
        queue_read(11'h7FF);
        queue_move(8'hFF, 8'hFF);
        queue_put(CH_BS);
        queue_move(8'(COLUMNS - 1), 8'(ROWS - 1));
        queue_put(8'h78);
        wait_drained();

        for (phase = 1; phase <= 5; phase++)
        begin
            case (phase)
                1:
                begin
                    write_colour(REG_BACKGROUND, 4'd15);
                    write_colour(REG_FOREGROUND, 4'd0);
                end
                2:
                begin
                    write_colour(REG_FOREGROUND, 4'd0);
                    write_colour(REG_BACKGROUND, 4'd0);
                end
                3:
                begin
                    write_colour(REG_BACKGROUND, 4'd15);
                    write_colour(REG_FOREGROUND, 4'd15);
                end
                default:
                begin
                    write_colour(REG_BACKGROUND, 4'($urandom));
                    write_colour(REG_FOREGROUND, 4'($urandom));
                end
            endcase
            @(negedge clk);
            if (phase == 2)
                queue_clear();
            queue_random(PHASE_ITEMS);
            wait_drained();
        end

        if (err_count == 0 && cursor_reports.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
